FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Check that cons holds in the same cycle as ante.
`define RAG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Check that cons holds in the cycle after ante.
`define RAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RAG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define RAG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/rag_pkg.sv
`timescale 1ns / 1ps
package rag_pkg;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RMW,
    ST_SWEEP,
    ST_SWEND,
    ST_SEND,
    ST_EMIT
  } rag_state_t;

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_DEADLOCK = 2'd1;
  localparam logic [1:0] STATUS_IGNORED  = 2'd2;
  localparam logic [1:0] STATUS_CLEARED  = 2'd3;

  // Input codes
  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_CLEAR    = 1'b1;
  localparam logic DIR_REQUEST = 1'b0;
  localparam logic DIR_ASSIGN  = 1'b1;

  // Field widths and limits
  localparam int ID_W         = 5;
  localparam int EDGE_W       = 16;
  localparam int RESULT_LIMIT = 32;
  localparam logic [EDGE_W-1:0] EDGE_MAX = 16'hFFFF;

endpackage

FILE: rtl/rag_ram.sv
`timescale 1ns / 1ps
module rag_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one row, read one row with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/rag_deadlock_detector_core.sv
`timescale 1ns / 1ps
// Deadlock detector on a resource allocation graph.
// Input channel (in_valid / in_stall) carries one operation per transfer:
// a clear, or one request or assignment edge. The result channel
// (out_valid / out_stall) returns one result per operation, or one result
// per stuck process when a deadlock appears; out_last marks the final one.
// A clear, or an edge seen after a deadlock, passes through ST_SEND into
// the output register, and no new transfer is taken until the block is
// back in ST_IDLE. A new edge goes through ST_RMW, which writes it into
// its RAM row (an id out of range skips ST_RMW), and then through K
// reduction rounds of ST_SWEEP and ST_SWEND, K at most PROCESSES +
// RESOURCES + 1. Each round sweeps every node row through the
// request and assignment RAMs, one read per cycle, so the RAM read port
// sets the pace. A deadlock then walks ids from 0 up to the highest stuck
// process, one result per stuck id. in_stall is high while an operation is busy.
// Reset (rst_n low, synchronous) empties the graph, the edge counter and
// the deadlock flag at once through per-row valid bits; no clearing pass
// is needed. A clear does the same. When the receiver stalls, the result
// holds in the output register and the block waits before loading more.
`include "assert_macros.svh"
module rag_deadlock_detector_core #(
  parameter int PROCESSES = 32,
  parameter int RESOURCES = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [rag_pkg::ID_W-1:0]    in_process_id,
  input  logic [rag_pkg::ID_W-1:0]    in_resource_id,
  input  logic                        in_direction,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [rag_pkg::ID_W-1:0]    out_stuck_process,
  output logic [rag_pkg::EDGE_W-1:0]  out_edge_number,
  output logic                        out_last
);
  import rag_pkg::*;

  localparam int PW    = $clog2(PROCESSES);
  localparam int RW    = $clog2(RESOURCES);
  localparam int NODES = PROCESSES + RESOURCES;
  localparam int CW    = $clog2(NODES);
  localparam int LIM   = (PROCESSES < RESULT_LIMIT) ? PROCESSES : RESULT_LIMIT;
  localparam int LW    = $clog2(LIM);

  rag_state_t state_r, state_nxt;
  logic [PROCESSES-1:0] req_vld_r, req_vld_nxt;
  logic [RESOURCES-1:0] asg_vld_r, asg_vld_nxt;
  logic                 halted_r, halted_nxt;
  logic [EDGE_W-1:0]    edge_cnt_r, edge_cnt_nxt;
  logic [EDGE_W-1:0]    edge_r, edge_nxt;
  logic [PW-1:0]        pid_r, pid_nxt;
  logic [RW-1:0]        rid_r, rid_nxt;
  logic                 dir_r, dir_nxt;
  logic [PROCESSES-1:0] live_p_r, live_p_nxt, live_p_ev;
  logic [RESOURCES-1:0] live_r_r, live_r_nxt, live_r_ev;
  logic                 changed_r, changed_nxt, ch_ev;
  logic [CW-1:0]        sw_cnt_r, sw_cnt_nxt, rix;
  logic                 ev_vld_r, ev_vld_nxt;
  logic                 ev_res_r, ev_res_nxt;
  logic [PW-1:0]        ev_pidx_r, ev_pidx_nxt;
  logic [RW-1:0]        ev_ridx_r, ev_ridx_nxt;
  logic                 req_rdv_r, asg_rdv_r;
  logic [LIM-1:0]       pend_r, pend_nxt, pend_rest;
  logic [LW-1:0]        em_i_r, em_i_nxt;
  logic [1:0]           send_status_r, send_status_nxt;

  logic                 out_valid_r, out_valid_nxt, out_load;
  logic [1:0]           out_status_r, out_status_nxt;
  logic [ID_W-1:0]      out_stuck_r, out_stuck_nxt;
  logic [EDGE_W-1:0]    out_edge_r, out_edge_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 req_we, asg_we;
  logic [PW-1:0]        req_waddr, req_raddr;
  logic [RW-1:0]        asg_waddr, asg_raddr;
  logic [RESOURCES-1:0] req_wdata, req_q, req_row;
  logic [PROCESSES-1:0] asg_wdata, asg_q, asg_row;

  logic [31:0]          pid_full, rid_full;
  logic                 in_range, slot_free;

  // Request rows: bit r of row p is set when process p requests resource r
  rag_ram #(.WIDTH(RESOURCES), .DEPTH(PROCESSES)) u_req_ram (
    .clk   (clk),
    .we    (req_we),
    .waddr (req_waddr),
    .wdata (req_wdata),
    .raddr (req_raddr),
    .rdata (req_q)
  );

  // Assignment rows: bit p of row r is set when resource r is held by process p
  rag_ram #(.WIDTH(PROCESSES), .DEPTH(RESOURCES)) u_asg_ram (
    .clk   (clk),
    .we    (asg_we),
    .waddr (asg_waddr),
    .wdata (asg_wdata),
    .raddr (asg_raddr),
    .rdata (asg_q)
  );

  // Rows never written since the last clear read as empty
  assign req_row = req_rdv_r ? req_q : '0;
  assign asg_row = asg_rdv_r ? asg_q : '0;

  assign pid_full  = 32'(in_process_id);
  assign rid_full  = 32'(in_resource_id);
  assign in_range  = (pid_full < 32'(PROCESSES)) && (rid_full < 32'(RESOURCES));
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);

  // Evaluate the row that came back from the RAM last cycle
  always_comb begin
    live_p_ev = live_p_r;
    live_r_ev = live_r_r;
    ch_ev     = 1'b0;
    if (ev_vld_r) begin
      if (!ev_res_r) begin
        if (live_p_r[ev_pidx_r] && ((req_row & live_r_r) == '0)) begin
          live_p_ev[ev_pidx_r] = 1'b0;
          ch_ev = 1'b1;
        end
      end else begin
        if (live_r_r[ev_ridx_r] && ((asg_row & live_p_r) == '0)) begin
          live_r_ev[ev_ridx_r] = 1'b0;
          ch_ev = 1'b1;
        end
      end
    end
  end

  // Next state and outputs
  always_comb begin
    state_nxt       = state_r;
    req_vld_nxt     = req_vld_r;
    asg_vld_nxt     = asg_vld_r;
    halted_nxt      = halted_r;
    edge_cnt_nxt    = edge_cnt_r;
    edge_nxt        = edge_r;
    pid_nxt         = pid_r;
    rid_nxt         = rid_r;
    dir_nxt         = dir_r;
    live_p_nxt      = live_p_r;
    live_r_nxt      = live_r_r;
    changed_nxt     = changed_r;
    sw_cnt_nxt      = sw_cnt_r;
    ev_vld_nxt      = 1'b0;
    ev_res_nxt      = ev_res_r;
    ev_pidx_nxt     = ev_pidx_r;
    ev_ridx_nxt     = ev_ridx_r;
    pend_nxt        = pend_r;
    em_i_nxt        = em_i_r;
    send_status_nxt = send_status_r;
    pend_rest       = pend_r;
    rix             = '0;
    req_we          = 1'b0;
    asg_we          = 1'b0;
    req_waddr       = pid_r;
    asg_waddr       = rid_r;
    req_wdata       = req_row | (RESOURCES'(1) << rid_r);
    asg_wdata       = asg_row | (PROCESSES'(1) << pid_r);
    req_raddr       = '0;
    asg_raddr       = '0;
    out_load        = 1'b0;
    out_valid_nxt   = out_valid_r && out_stall;
    out_status_nxt  = send_status_r;
    out_stuck_nxt   = '0;
    out_edge_nxt    = edge_r;
    out_last_nxt    = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_CLEAR) begin
            req_vld_nxt     = '0;
            asg_vld_nxt     = '0;
            halted_nxt      = 1'b0;
            edge_cnt_nxt    = '0;
            edge_nxt        = '0;
            send_status_nxt = STATUS_CLEARED;
            state_nxt       = ST_SEND;
          end else begin
            edge_nxt = edge_cnt_r;
            if (edge_cnt_r != EDGE_MAX) begin
              edge_cnt_nxt = edge_cnt_r + 1'b1;
            end
            if (halted_r) begin
              send_status_nxt = STATUS_IGNORED;
              state_nxt       = ST_SEND;
            end else begin
              pid_nxt     = pid_full[PW-1:0];
              rid_nxt     = rid_full[RW-1:0];
              dir_nxt     = in_direction;
              req_raddr   = pid_full[PW-1:0];
              asg_raddr   = rid_full[RW-1:0];
              live_p_nxt  = '1;
              live_r_nxt  = '1;
              changed_nxt = 1'b0;
              sw_cnt_nxt  = '0;
              state_nxt   = in_range ? ST_RMW : ST_SWEEP;
            end
          end
        end
      end

      ST_RMW: begin
        // Merge the new edge into its row and write it back
        if (dir_r == DIR_REQUEST) begin
          req_we             = 1'b1;
          req_vld_nxt[pid_r] = 1'b1;
        end else begin
          asg_we             = 1'b1;
          asg_vld_nxt[rid_r] = 1'b1;
        end
        state_nxt = ST_SWEEP;
      end

      ST_SWEEP: begin
        // Issue one node row a cycle: processes first, then resources
        ev_vld_nxt = 1'b1;
        if (sw_cnt_r < CW'(PROCESSES)) begin
          req_raddr   = sw_cnt_r[PW-1:0];
          ev_pidx_nxt = sw_cnt_r[PW-1:0];
          ev_res_nxt  = 1'b0;
        end else begin
          rix         = sw_cnt_r - CW'(PROCESSES);
          asg_raddr   = rix[RW-1:0];
          ev_ridx_nxt = rix[RW-1:0];
          ev_res_nxt  = 1'b1;
        end
        live_p_nxt  = live_p_ev;
        live_r_nxt  = live_r_ev;
        changed_nxt = changed_r | ch_ev;
        if (sw_cnt_r == CW'(NODES - 1)) begin
          state_nxt = ST_SWEND;
        end else begin
          sw_cnt_nxt = CW'(sw_cnt_r + 1'b1);
        end
      end

      ST_SWEND: begin
        // Close the round: sweep again on any removal, else report
        live_p_nxt = live_p_ev;
        live_r_nxt = live_r_ev;
        if (changed_r | ch_ev) begin
          sw_cnt_nxt  = '0;
          changed_nxt = 1'b0;
          state_nxt   = ST_SWEEP;
        end else if (live_p_ev[LIM-1:0] == '0) begin
          send_status_nxt = STATUS_OK;
          state_nxt       = ST_SEND;
        end else begin
          pend_nxt  = live_p_ev[LIM-1:0];
          em_i_nxt  = '0;
          state_nxt = ST_EMIT;
        end
      end

      ST_SEND: begin
        // Load the single result once the output register frees up
        if (slot_free) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_EMIT: begin
        // Walk stuck processes in ascending id order
        if (pend_r[em_i_r]) begin
          if (slot_free) begin
            pend_rest      = pend_r & ~(LIM'(1) << em_i_r);
            out_load       = 1'b1;
            out_valid_nxt  = 1'b1;
            out_status_nxt = STATUS_DEADLOCK;
            out_stuck_nxt  = ID_W'(em_i_r);
            out_last_nxt   = (pend_rest == '0);
            pend_nxt       = pend_rest;
            em_i_nxt       = LW'(em_i_r + 1'b1);
            if (pend_rest == '0) begin
              halted_nxt = 1'b1;
              state_nxt  = ST_IDLE;
            end
          end
        end else begin
          em_i_nxt = LW'(em_i_r + 1'b1);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      req_vld_r   <= '0;
      asg_vld_r   <= '0;
      halted_r    <= 1'b0;
      edge_cnt_r  <= '0;
      ev_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      req_vld_r   <= req_vld_nxt;
      asg_vld_r   <= asg_vld_nxt;
      halted_r    <= halted_nxt;
      edge_cnt_r  <= edge_cnt_nxt;
      ev_vld_r    <= ev_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    edge_r        <= edge_nxt;
    pid_r         <= pid_nxt;
    rid_r         <= rid_nxt;
    dir_r         <= dir_nxt;
    live_p_r      <= live_p_nxt;
    live_r_r      <= live_r_nxt;
    changed_r     <= changed_nxt;
    sw_cnt_r      <= sw_cnt_nxt;
    ev_res_r      <= ev_res_nxt;
    ev_pidx_r     <= ev_pidx_nxt;
    ev_ridx_r     <= ev_ridx_nxt;
    pend_r        <= pend_nxt;
    em_i_r        <= em_i_nxt;
    send_status_r <= send_status_nxt;
    req_rdv_r     <= req_vld_r[req_raddr];
    asg_rdv_r     <= asg_vld_r[asg_raddr];
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_stuck_r  <= out_stuck_nxt;
      out_edge_r   <= out_edge_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_stuck_process = out_stuck_r;
  assign out_edge_number   = out_edge_r;
  assign out_last          = out_last_r;

  // Checks
  `RAG_ASSERT_IMPLY(a_single_last, clk, rst_n, out_valid_r && (out_status_r != STATUS_DEADLOCK), out_last_r)
  `RAG_ASSERT_IMPLY(a_clear_zero, clk, rst_n, out_valid_r && (out_status_r == STATUS_CLEARED), (out_edge_r == '0) && (out_stuck_r == '0))
  `RAG_ASSERT_IMPLY(a_no_sweep_halted, clk, rst_n, (state_r == ST_SWEEP) || (state_r == ST_SWEND), !halted_r)
  `RAG_ASSERT_NEXT(a_halt_after_last, clk, rst_n, (state_r == ST_EMIT) && out_load && out_last_nxt, halted_r)

endmodule

FILE: dv/rag_deadlock_detector_core_tb.sv
`timescale 1ns / 1ps
module rag_deadlock_detector_core_tb;
  import rag_pkg::*;

  localparam int NODES       = 32;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int DRAIN_WAIT  = 200;
  localparam int HALT_EDGES  = 6;

  typedef struct packed {
    logic            op;
    logic [ID_W-1:0] pid;
    logic [ID_W-1:0] rid;
    logic            dir;
  } graph_op_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ID_W-1:0]   stuck;
    logic [EDGE_W-1:0] edge_num;
    logic              last;
  } rag_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_op;
  logic [ID_W-1:0] in_process_id;
  logic [ID_W-1:0] in_resource_id;
  logic in_direction;
  logic out_valid;
  logic out_stall;
  logic [1:0] out_status;
  logic [ID_W-1:0] out_stuck_process;
  logic [EDGE_W-1:0] out_edge_number;
  logic out_last;

  rag_deadlock_detector_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_process_id(in_process_id), .in_resource_id(in_resource_id),
    .in_direction(in_direction),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_stuck_process(out_stuck_process), .out_edge_number(out_edge_number),
    .out_last(out_last)
  );

  // Shadow graph state
  logic [NODES-1:0]  req_rows [NODES] = '{default: '0};
  logic [NODES-1:0]  asg_rows [NODES] = '{default: '0};
  logic [EDGE_W-1:0] edge_count = '0;
  logic              is_halted = 1'b0;

  graph_op_t   pending_ops[$];
  rag_result_t expected_results[$];
  int errors = 0;
  int ops_accepted = 0;
  int results_seen = 0;
  int deadlocks_seen = 0;
  int cycle_count = 0;

  // Append one operation to the stimulus queue
  task automatic add_pending(input graph_op_t g);
    pending_ops = {pending_ops, g};
  endtask

  // Append one result to the scoreboard queue
  task automatic add_expected(input rag_result_t r);
    expected_results = {expected_results, r};
  endtask

  // Compute expected results of one accepted operation and update the shadow graph
  task automatic predict_graph_op(input graph_op_t g);
    logic [NODES-1:0] live_p;
    logic [NODES-1:0] live_r;
    logic [EDGE_W-1:0] this_edge;
    logic changed;
    int n;
    rag_result_t r;
    if (g.op == OP_CLEAR) begin
      foreach (req_rows[i]) begin
        req_rows[i] = '0;
        asg_rows[i] = '0;
      end
      edge_count = '0;
      is_halted = 1'b0;
      r = '{STATUS_CLEARED, '0, '0, 1'b1};
      add_expected(r);
      return;
    end
    this_edge = edge_count;
    if (edge_count != EDGE_MAX) edge_count = edge_count + 1'b1;
    if (is_halted) begin
      r = '{STATUS_IGNORED, '0, this_edge, 1'b1};
      add_expected(r);
      return;
    end
    if (g.dir == DIR_REQUEST) req_rows[g.pid][g.rid] = 1'b1;
    else asg_rows[g.rid][g.pid] = 1'b1;
    // Peel off nodes with no outgoing edge to a live node until nothing moves
    live_p = '1;
    live_r = '1;
    changed = 1'b1;
    while (changed) begin
      changed = 1'b0;
      for (int i = 0; i < NODES; i++) begin
        if (live_p[i] && (req_rows[i] & live_r) == '0) begin
          live_p[i] = 1'b0;
          changed = 1'b1;
        end
      end
      for (int i = 0; i < NODES; i++) begin
        if (live_r[i] && (asg_rows[i] & live_p) == '0) begin
          live_r[i] = 1'b0;
          changed = 1'b1;
        end
      end
    end
    if (live_p == '0) begin
      r = '{STATUS_OK, '0, this_edge, 1'b1};
      add_expected(r);
      return;
    end
    n = $countones(live_p);
    for (int i = 0; i < NODES; i++) begin
      if (live_p[i]) begin
        n--;
        r = '{STATUS_DEADLOCK, i[ID_W-1:0], this_edge, (n == 0)};
        add_expected(r);
      end
    end
    is_halted = 1'b1;
    deadlocks_seen++;
  endtask

  function automatic graph_op_t mk_op(input logic op, input int p, input int r,
                                      input logic dir);
    graph_op_t g;
    g.op = op;
    g.pid = p[ID_W-1:0];
    g.rid = r[ID_W-1:0];
    g.dir = dir;
    return g;
  endfunction

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Reset and cycle watchdog
  initial begin
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout with %0d results still expected", $time,
               expected_results.size());
      $display("rag_deadlock_detector_core_tb NOT OK");
      $finish;
    end
  end

  // Driver: offer queued operations in bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    graph_op_t g;
    logic nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_op <= OP_ADD;
      in_process_id <= '0;
      in_resource_id <= '0;
      in_direction <= DIR_REQUEST;
    end else if (!(in_valid && in_stall)) begin
      nv = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_ops.size() > 0) begin
        g = pending_ops.pop_front();
        in_op <= g.op;
        in_process_id <= g.pid;
        in_resource_id <= g.rid;
        in_direction <= g.dir;
        nv = 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      in_valid <= nv;
    end
  end

  // Receiver stall pattern, with one long hold-off to back up the block
  int hold_left = 0;
  logic hold_done = 1'b0;
  int stall_mode = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && ops_accepted >= 30) begin
        hold_done = 1'b1;
        hold_left = 400;
      end
      if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  // Monitor: predict on input transfers, check on result transfers
  always @(posedge clk) begin
    rag_result_t got;
    rag_result_t exp_r;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_graph_op(mk_op(in_op, int'(in_process_id), int'(in_resource_id),
                               in_direction));
        ops_accepted++;
      end
      if (out_valid && !out_stall) begin
        got = '{out_status, out_stuck_process, out_edge_number, out_last};
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result: expected none, actual %p", $time, got);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.status !== exp_r.status) begin
            $display("%0t status: expected %0d actual %0d", $time, exp_r.status, got.status);
            errors++;
          end
          if (got.stuck !== exp_r.stuck) begin
            $display("%0t stuck_process: expected %0d actual %0d", $time, exp_r.stuck,
                     got.stuck);
            errors++;
          end
          if (got.edge_num !== exp_r.edge_num) begin
            $display("%0t edge_number: expected %0d actual %0d", $time, exp_r.edge_num,
                     got.edge_num);
            errors++;
          end
          if (got.last !== exp_r.last) begin
            $display("%0t last: expected %0d actual %0d", $time, exp_r.last, got.last);
            errors++;
          end
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    int span;
    int n_edges;
    int total;

    // Directed: two-process cycle, ignored edge, clears, extreme ids
    add_pending(mk_op(OP_ADD, 0, 0, DIR_REQUEST));
    add_pending(mk_op(OP_ADD, 1, 0, DIR_ASSIGN));
    add_pending(mk_op(OP_ADD, 1, 1, DIR_REQUEST));
    add_pending(mk_op(OP_ADD, 1, 1, DIR_REQUEST));
    add_pending(mk_op(OP_ADD, 0, 1, DIR_ASSIGN));
    add_pending(mk_op(OP_ADD, 31, 31, DIR_ASSIGN));
    add_pending(mk_op(OP_CLEAR, 31, 31, DIR_ASSIGN));
    add_pending(mk_op(OP_ADD, 31, 31, DIR_REQUEST));
    add_pending(mk_op(OP_ADD, 31, 31, DIR_ASSIGN));
    add_pending(mk_op(OP_ADD, 0, 31, DIR_REQUEST));
    add_pending(mk_op(OP_CLEAR, 0, 0, DIR_REQUEST));
    add_pending(mk_op(OP_ADD, 31, 0, DIR_REQUEST));
    add_pending(mk_op(OP_ADD, 0, 31, DIR_ASSIGN));
    add_pending(mk_op(OP_ADD, 0, 0, DIR_REQUEST));
    add_pending(mk_op(OP_ADD, 31, 0, DIR_ASSIGN));
    add_pending(mk_op(OP_CLEAR, 0, 0, DIR_REQUEST));

    // Ring through every process and resource: deadlock with all 32 stuck
    for (int i = 0; i < NODES; i++) begin
      add_pending(mk_op(OP_ADD, i, i, DIR_REQUEST));
      add_pending(mk_op(OP_ADD, (i + 1) % NODES, i, DIR_ASSIGN));
    end
    add_pending(mk_op(OP_CLEAR, 0, 0, DIR_REQUEST));

    // Random episodes over small node sets so cycles form often
    total = 0;
    while (total < 165) begin
      add_pending(mk_op(OP_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31),
                        1'($urandom_range(0, 1))));
      span = $urandom_range(2, 6);
      n_edges = $urandom_range(3, 16);
      for (int k = 0; k < n_edges; k++) begin
        if ($urandom_range(0, 9) == 0)
          add_pending(mk_op(OP_ADD, $urandom_range(0, 31), $urandom_range(0, 31),
                            1'($urandom_range(0, 1))));
        else
          add_pending(mk_op(OP_ADD, $urandom_range(0, span - 1),
                            $urandom_range(0, span - 1), 1'($urandom_range(0, 1))));
      end
      if ($urandom_range(0, 7) == 0)
        add_pending(mk_op(1'($urandom_range(0, 1)), $urandom_range(0, 31),
                          $urandom_range(0, 31), 1'($urandom_range(0, 1))));
      total += n_edges + 1;
    end

    // Halt on a self-loop, offer edges while halted, then clear and restart
    add_pending(mk_op(OP_CLEAR, 0, 0, DIR_REQUEST));
    add_pending(mk_op(OP_ADD, 5, 9, DIR_REQUEST));
    add_pending(mk_op(OP_ADD, 5, 9, DIR_ASSIGN));
    for (int k = 0; k < HALT_EDGES; k++)
      add_pending(mk_op(OP_ADD, $urandom_range(0, 31), $urandom_range(0, 31),
                        1'($urandom_range(0, 1))));
    add_pending(mk_op(OP_CLEAR, 0, 0, DIR_REQUEST));
    add_pending(mk_op(OP_ADD, 3, 3, DIR_REQUEST));

    @(posedge rst_n);
    while (pending_ops.size() > 0 || in_valid) @(posedge clk);
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d operations, %0d results, %0d deadlocks incl. a 32-process ring",
             ops_accepted, results_seen, deadlocks_seen);
    $display("edges offered while halted, clears and a long output hold-off; %0d mismatches",
             errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("rag_deadlock_detector_core_tb OK");
    end else begin
      $display("rag_deadlock_detector_core_tb NOT OK");
    end
    $finish;
  end

endmodule
